// ===== rtl/ercq_pkg.sv =====
// Shared types, codes and default sizes for the event coalescing ready queue.
package ercq_pkg;

   // Fixed field widths of the item ports.
   localparam int ACTION_W = 2;
   localparam int SOCKET_W = 6;
   localparam int BITS_W   = 8;
   localparam int TAG_W    = 32;
   localparam int STATUS_W = 3;

   // Default sizes.
   localparam int SOCKET_COUNT_DEF      = 64;
   localparam int MAX_REGISTRATIONS_DEF = 32;
   localparam int EVENT_WIDTH_DEF       = 8;

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_REGISTER   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_UNREGISTER = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_SIGNAL     = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_POP        = 2'd3;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOTREG  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_DUP     = 3'd4;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [SOCKET_W-1:0] socket_id;
      logic [BITS_W-1:0]   event_bits;
      logic [TAG_W-1:0]    user_tag;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BITS_W-1:0]   ready_bits;
      logic [SOCKET_W-1:0] ready_socket;
      logic [TAG_W-1:0]    ready_tag;
   } rsp_type;

endpackage

// ===== rtl/event_coalescing_ready_queue_top.sv =====
// Top level of the event coalescing ready queue: sequencer, table and output register.
//
// Usage:
//   req_valid/req_stall/req_item carry one action per item: register, unregister,
//   signal or pop. rsp_valid/rsp_stall/rsp_item return exactly one result item
//   per accepted item, in order: status plus, for a successful pop, the
//   coalesced event mask, socket and tag of the oldest pending event.
//   An item is taken at a rising edge with valid high and stall low.
// Sequencing:
//   An accepted item reads its table entry (registered RAM read) and resolves in
//   the next cycle. Appending behind an existing event needs one more table
//   write; unregistering an event from the middle of the ready list needs two
//   more. The single write port of the table serializes these writes.
//   One item is in flight at a time; the result lands in the output register
//   in the item's last cycle.
// Reset and stall:
//   After reset the sequencer sweeps all SOCKET_COUNT table entries,
//   clearing every registration and pending flag; req_stall stays high until
//   the sweep ends. While rsp_stall holds a result, the next item may still be
//   accepted and worked on; its result waits until the output register frees.
module event_coalescing_ready_queue_top #(
   parameter int SOCKET_COUNT      = ercq_pkg::SOCKET_COUNT_DEF,
   parameter int MAX_REGISTRATIONS = ercq_pkg::MAX_REGISTRATIONS_DEF,
   parameter int EVENT_WIDTH       = ercq_pkg::EVENT_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ercq_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ercq_pkg::rsp_type rsp_item
);

   logic              idle;
   logic              out_free;
   logic              res_push;
   ercq_pkg::rsp_type res_data;
   logic              rsp_valid_ff;
   ercq_pkg::rsp_type rsp_item_ff;

   // The output slot frees when empty or when its item leaves this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // Take a new item only while the sequencer is idle.
   assign req_stall = !idle;

   ercq_ctrl #(
      .SOCKET_COUNT      (SOCKET_COUNT),
      .MAX_REGISTRATIONS (MAX_REGISTRATIONS),
      .EVENT_WIDTH       (EVENT_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_item  (req_item),
      .idle      (idle),
      .out_free  (out_free),
      .res_push  (res_push),
      .res_data  (res_data)
   );

   // Output register: load on push, drop once the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_push) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         rsp_item_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== rtl/ercq_table.sv =====
// Per-socket table: single-port-write, single-port-read RAM with bit write enables.
module ercq_table #(
   parameter int DEPTH  = ercq_pkg::SOCKET_COUNT_DEF,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [DATA_W-1:0] wr_mask
);

   logic [DATA_W-1:0] entry_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int i = 0; i < DATA_W; i++) begin
            if (wr_mask[i]) begin
               entry_mem[wr_addr][i] <= wr_data[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ercq_ctrl.sv =====
// Sequencer: table clearing, per-action read-modify-write, ready list pointers and links.
module ercq_ctrl #(
   parameter int SOCKET_COUNT      = ercq_pkg::SOCKET_COUNT_DEF,
   parameter int MAX_REGISTRATIONS = ercq_pkg::MAX_REGISTRATIONS_DEF,
   parameter int EVENT_WIDTH       = ercq_pkg::EVENT_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  ercq_pkg::req_type req_item,
   output logic             idle,
   input  logic             out_free,
   output logic             res_push,
   output ercq_pkg::rsp_type res_data
);

   localparam int IDX_W     = $clog2(SOCKET_COUNT);
   localparam int CNT_W     = $clog2(MAX_REGISTRATIONS + 1);
   localparam int EW        = EVENT_WIDTH;
   localparam int TW        = ercq_pkg::TAG_W;
   // Entry layout, low to high.
   localparam int OLDER_LSB = 0;
   localparam int NEWER_LSB = IDX_W;
   localparam int TAG_LSB   = 2 * IDX_W;
   localparam int PMASK_LSB = TAG_LSB + TW;
   localparam int INT_LSB   = PMASK_LSB + EW;
   localparam int PEND_BIT  = INT_LSB + EW;
   localparam int REG_BIT   = PEND_BIT + 1;
   localparam int ENTRY_W   = REG_BIT + 1;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SOCKET_COUNT - 1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_LINK1 = 3'd3;
   localparam logic [2:0] S_LINK2 = 3'd4;
   localparam logic [2:0] S_WAIT  = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic [IDX_W-1:0]   oldest_ff, oldest_in;
   logic [IDX_W-1:0]   newest_ff, newest_in;
   logic               empty_ff, empty_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   lk_a_ff, lk_a_in;
   logic [IDX_W-1:0]   lk_b_ff, lk_b_in;
   logic               need2_ff, need2_in;
   ercq_pkg::rsp_type  res_ff, res_in;
   ercq_pkg::req_type  item_ff;
   logic [IDX_W-1:0]   ent_addr_ff;

   logic               accept;
   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] wr_mask;

   logic               e_reg;
   logic               e_pend;
   logic [EW-1:0]      e_int;
   logic [EW-1:0]      e_pmask;
   logic [TW-1:0]      e_tag;
   logic [IDX_W-1:0]   e_newer;
   logic [IDX_W-1:0]   e_older;
   logic               sid_valid;
   logic [IDX_W-1:0]   sid_ix;
   logic [EW-1:0]      ev_bits;

   assign accept  = (state_ff == S_IDLE) && req_valid;
   assign idle    = (state_ff == S_IDLE);
   assign rd_addr = (req_item.action == ercq_pkg::ACT_POP) ? oldest_ff
                                                           : IDX_W'(req_item.socket_id);

   ercq_table #(
      .DEPTH  (SOCKET_COUNT),
      .ADDR_W (IDX_W),
      .DATA_W (ENTRY_W)
   ) u_table (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .wr_mask (wr_mask)
   );

   assign e_reg     = rd_data[REG_BIT];
   assign e_pend    = rd_data[PEND_BIT];
   assign e_int     = rd_data[INT_LSB +: EW];
   assign e_pmask   = rd_data[PMASK_LSB +: EW];
   assign e_tag     = rd_data[TAG_LSB +: TW];
   assign e_newer   = rd_data[NEWER_LSB +: IDX_W];
   assign e_older   = rd_data[OLDER_LSB +: IDX_W];
   assign sid_valid = 32'(item_ff.socket_id) < SOCKET_COUNT;
   assign sid_ix    = IDX_W'(item_ff.socket_id);
   assign ev_bits   = EW'(item_ff.event_bits);

   always_comb begin
      logic [EW-1:0]     rem;
      logic [EW-1:0]     hit;
      logic              go_link;
      ercq_pkg::rsp_type res_c;

      state_in  = state_ff;
      clr_in    = clr_ff;
      oldest_in = oldest_ff;
      newest_in = newest_ff;
      empty_in  = empty_ff;
      count_in  = count_ff;
      lk_a_in   = lk_a_ff;
      lk_b_in   = lk_b_ff;
      need2_in  = need2_ff;
      res_in    = res_ff;
      wr_en     = 1'b0;
      wr_addr   = ent_addr_ff;
      wr_data   = '0;
      wr_mask   = '0;
      res_push  = 1'b0;
      res_data  = res_ff;
      rem       = e_int & ~ev_bits;
      hit       = ev_bits & e_int;
      go_link   = 1'b0;
      res_c     = '0;
      res_c.status = ercq_pkg::STATUS_OK;

      case (state_ff)
         S_CLEAR: begin
            // Sweep the table, dropping every registration and pending flag.
            wr_en             = 1'b1;
            wr_addr           = clr_ff;
            wr_mask[REG_BIT]  = 1'b1;
            wr_mask[PEND_BIT] = 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (item_ff.action)
               ercq_pkg::ACT_REGISTER: begin
                  if (ev_bits == '0) begin
                     res_c.status = ercq_pkg::STATUS_OK;
                  end else if (!sid_valid) begin
                     res_c.status = ercq_pkg::STATUS_NOTREG;
                  end else if (e_reg) begin
                     res_c.status = ercq_pkg::STATUS_DUP;
                  end else if (32'(count_ff) >= MAX_REGISTRATIONS) begin
                     res_c.status = ercq_pkg::STATUS_FULL;
                  end else begin
                     wr_en                      = 1'b1;
                     wr_mask[REG_BIT]           = 1'b1;
                     wr_mask[PEND_BIT]          = 1'b1;
                     wr_mask[INT_LSB +: EW]     = '1;
                     wr_mask[TAG_LSB +: TW]     = '1;
                     wr_data[REG_BIT]           = 1'b1;
                     wr_data[INT_LSB +: EW]     = ev_bits;
                     wr_data[TAG_LSB +: TW]     = item_ff.user_tag;
                     count_in                   = count_ff + 1'b1;
                  end
               end
               ercq_pkg::ACT_UNREGISTER: begin
                  if (!sid_valid || !e_reg) begin
                     res_c.status = ercq_pkg::STATUS_NOTREG;
                  end else if (rem != '0) begin
                     wr_en                  = 1'b1;
                     wr_mask[INT_LSB +: EW] = '1;
                     wr_data[INT_LSB +: EW] = rem;
                  end else begin
                     wr_en             = 1'b1;
                     wr_mask[REG_BIT]  = 1'b1;
                     wr_mask[PEND_BIT] = 1'b1;
                     if (count_ff != '0) begin
                        count_in = count_ff - 1'b1;
                     end
                     if (e_pend && !empty_ff) begin
                        // Unlink the socket's pending event.
                        if (sid_ix == oldest_ff && sid_ix == newest_ff) begin
                           empty_in = 1'b1;
                        end else if (sid_ix == oldest_ff) begin
                           oldest_in = e_newer;
                        end else if (sid_ix == newest_ff) begin
                           newest_in = e_older;
                        end else begin
                           lk_a_in  = e_older;
                           lk_b_in  = e_newer;
                           need2_in = 1'b1;
                           go_link  = 1'b1;
                        end
                     end
                  end
               end
               ercq_pkg::ACT_SIGNAL: begin
                  if (sid_valid && e_reg && hit != '0) begin
                     wr_en                    = 1'b1;
                     wr_mask[PMASK_LSB +: EW] = '1;
                     if (e_pend) begin
                        // Coalesce into the event already queued.
                        wr_data[PMASK_LSB +: EW] = e_pmask | hit;
                     end else begin
                        // Append a new event at the newest end.
                        wr_mask[PEND_BIT]          = 1'b1;
                        wr_mask[NEWER_LSB +: IDX_W] = '1;
                        wr_mask[OLDER_LSB +: IDX_W] = '1;
                        wr_data[PEND_BIT]          = 1'b1;
                        wr_data[PMASK_LSB +: EW]   = hit;
                        wr_data[NEWER_LSB +: IDX_W] = sid_ix;
                        if (empty_ff) begin
                           wr_data[OLDER_LSB +: IDX_W] = sid_ix;
                           oldest_in = sid_ix;
                        end else begin
                           wr_data[OLDER_LSB +: IDX_W] = newest_ff;
                           lk_a_in  = newest_ff;
                           lk_b_in  = sid_ix;
                           need2_in = 1'b0;
                           go_link  = 1'b1;
                        end
                        newest_in = sid_ix;
                        empty_in  = 1'b0;
                     end
                  end
               end
               ercq_pkg::ACT_POP: begin
                  if (empty_ff) begin
                     res_c.status = ercq_pkg::STATUS_EMPTY;
                  end else begin
                     res_c.ready_bits   = ercq_pkg::BITS_W'(e_pmask);
                     res_c.ready_socket = ercq_pkg::SOCKET_W'(ent_addr_ff);
                     res_c.ready_tag    = e_tag;
                     wr_en              = 1'b1;
                     wr_mask[PEND_BIT]  = 1'b1;
                     if (ent_addr_ff == newest_ff) begin
                        empty_in = 1'b1;
                     end else begin
                        oldest_in = e_newer;
                     end
                  end
               end
               default: begin
                  res_c.status = ercq_pkg::STATUS_OK;
               end
            endcase
            res_in = res_c;
            if (go_link) begin
               state_in = S_LINK1;
            end else if (out_free) begin
               res_push = 1'b1;
               res_data = res_c;
               state_in = S_IDLE;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_LINK1: begin
            // Point the older neighbor forward.
            wr_en                       = 1'b1;
            wr_addr                     = lk_a_ff;
            wr_mask[NEWER_LSB +: IDX_W] = '1;
            wr_data[NEWER_LSB +: IDX_W] = lk_b_ff;
            if (need2_ff) begin
               state_in = S_LINK2;
            end else if (out_free) begin
               res_push = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_LINK2: begin
            // Point the newer neighbor back.
            wr_en                       = 1'b1;
            wr_addr                     = lk_b_ff;
            wr_mask[OLDER_LSB +: IDX_W] = '1;
            wr_data[OLDER_LSB +: IDX_W] = lk_a_ff;
            if (out_free) begin
               res_push = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (out_free) begin
               res_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         oldest_ff <= '0;
         newest_ff <= '0;
         empty_ff  <= 1'b1;
         count_ff  <= '0;
         need2_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         oldest_ff <= oldest_in;
         newest_ff <= newest_in;
         empty_ff  <= empty_in;
         count_ff  <= count_in;
         need2_ff  <= need2_in;
      end
   end

   always_ff @(posedge clock) begin
      lk_a_ff <= lk_a_in;
      lk_b_ff <= lk_b_in;
      res_ff  <= res_in;
      if (accept) begin
         item_ff     <= req_item;
         ent_addr_ff <= rd_addr;
      end
   end

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_EXEC)
      else $error("accepted item did not move to execute");

   a_push_to_idle: assert property (@(posedge clock) disable iff (reset)
      res_push |=> state_ff == S_IDLE)
      else $error("result handed over without returning to idle");

   a_wait_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT && !out_free) |=> state_ff == S_WAIT)
      else $error("left wait while the output register was occupied");

   a_no_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff != S_IDLE)
      else $error("table written while idle");

endmodule

// ===== dv/event_coalescing_ready_queue_top_test.sv =====
// Self-checking testbench for the event coalescing ready queue top level.
module event_coalescing_ready_queue_top_test;

   localparam int CLOCK_PERIOD  = 12;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int LONG_HOLD     = 300;
   localparam int PHASE_ITEMS   = 260;
   localparam int PHASE_COUNT   = 6;
   localparam int SETTLE_CYCLES = 8;

   // Traffic mixes for the random phases.
   typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_kind_type;

   // One row of the directed table: the item, plus a hand-written result where
   // the answer is obvious from the spec.
   typedef struct {
      ercq_pkg::req_type item;
      bit                typed;
      ercq_pkg::rsp_type want;
   } dir_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   ercq_pkg::req_type req_item = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   ercq_pkg::rsp_type rsp_item;

   // Shadow of the ready list. Bit types start at zero, which matches reset;
   // entries that reset leaves undefined are only read after being written.
   bit        sock_live[64];
   bit [7:0]  sock_interest[64];
   bit [31:0] sock_tag[64];
   bit        ev_pending[64];
   bit [7:0]  ev_mask[64];
   bit [5:0]  toward_new[64];
   bit [5:0]  toward_old[64];
   bit [5:0]  head_sock;
   bit [5:0]  tail_sock;
   bit        list_empty = 1'b1;
   int        live_count;

   ercq_pkg::rsp_type pending_results[$];
   dir_row_type       dir_rows[$];

   int  fail_count;
   int  items_sent;
   int  results_seen;
   int  merged_signals;
   int  data_pops;
   int  status_seen[5];
   bit  calm;        // no idling on either side once set
   bit  hold_req;    // ask the receiver for one long hold-off

   event_coalescing_ready_queue_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial begin
      forever begin
         #(CLOCK_PERIOD / 2) clock = ~clock;
      end
   end

   // ------------------------------------------------------------------
   // Ready list predictor
   // ------------------------------------------------------------------

   // Append a fresh event for socket s at the newest end.
   task automatic link_event(input int s, input bit [7:0] m);
      ev_pending[s] = 1'b1;
      ev_mask[s] = m;
      if (list_empty) begin
         head_sock = s[5:0];
         toward_old[s] = s[5:0];
      end else begin
         toward_new[tail_sock] = s[5:0];
         toward_old[s] = tail_sock;
      end
      toward_new[s] = s[5:0];
      tail_sock = s[5:0];
      list_empty = 1'b0;
   endtask

   // Take socket s out of the list, wherever it sits.
   task automatic unlink_event(input int s);
      bit [5:0] o;
      bit [5:0] n;
      ev_pending[s] = 1'b0;
      if (!list_empty) begin
         if (s == head_sock && s == tail_sock) begin
            list_empty = 1'b1;
         end else if (s == head_sock) begin
            head_sock = toward_new[s];
         end else if (s == tail_sock) begin
            tail_sock = toward_old[s];
         end else begin
            o = toward_old[s];
            n = toward_new[s];
            toward_new[o] = n;
            toward_old[n] = o;
         end
      end
   endtask

   // Apply one item to the shadow and return the result the block owes.
   task automatic predict_ready_list(input ercq_pkg::req_type it,
                                     output ercq_pkg::rsp_type res);
      int       s;
      bit [7:0] bits;
      bit [7:0] hit;
      bit [7:0] rem;
      res = '0;
      res.status = ercq_pkg::STATUS_OK;
      s = int'(it.socket_id);
      bits = it.event_bits;
      case (it.action)
         ercq_pkg::ACT_REGISTER: begin
            if (bits == 8'h00) begin
               res.status = ercq_pkg::STATUS_OK;
            end else if (sock_live[s]) begin
               res.status = ercq_pkg::STATUS_DUP;
            end else if (live_count >= ercq_pkg::MAX_REGISTRATIONS_DEF) begin
               res.status = ercq_pkg::STATUS_FULL;
            end else begin
               sock_live[s] = 1'b1;
               sock_interest[s] = bits;
               sock_tag[s] = it.user_tag;
               ev_pending[s] = 1'b0;
               live_count++;
            end
         end
         ercq_pkg::ACT_UNREGISTER: begin
            if (!sock_live[s]) begin
               res.status = ercq_pkg::STATUS_NOTREG;
            end else begin
               rem = sock_interest[s] & ~bits;
               if (rem == 8'h00) begin
                  if (ev_pending[s]) unlink_event(s);
                  sock_live[s] = 1'b0;
                  if (live_count > 0) live_count--;
               end else begin
                  sock_interest[s] = rem;
               end
            end
         end
         ercq_pkg::ACT_SIGNAL: begin
            if (sock_live[s]) begin
               hit = bits & sock_interest[s];
               if (hit != 8'h00) begin
                  if (ev_pending[s]) begin
                     ev_mask[s] |= hit;
                     merged_signals++;
                  end else begin
                     link_event(s, hit);
                  end
               end
            end
         end
         ercq_pkg::ACT_POP: begin
            if (list_empty) begin
               res.status = ercq_pkg::STATUS_EMPTY;
            end else begin
               s = int'(head_sock);
               res.ready_bits = ev_mask[s];
               res.ready_socket = head_sock;
               res.ready_tag = sock_tag[s];
               unlink_event(s);
            end
         end
         default: begin
            res.status = ercq_pkg::STATUS_OK;
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   task automatic add_row(input logic [ercq_pkg::ACTION_W-1:0] act, input int sock,
                          input int bits, input logic [31:0] tag, input bit typed,
                          input logic [ercq_pkg::STATUS_W-1:0] st, input int rbits,
                          input int rsock, input logic [31:0] rtag);
      dir_row_type r;
      r.item.action = act;
      r.item.socket_id = sock[5:0];
      r.item.event_bits = bits[7:0];
      r.item.user_tag = tag;
      r.typed = typed;
      r.want.status = st;
      r.want.ready_bits = rbits[7:0];
      r.want.ready_socket = rsock[5:0];
      r.want.ready_tag = rtag;
      dir_rows.push_back(r);
   endtask

   // Mostly pick a socket that is live, so signals and unregisters land;
   // the rest hit random sockets as noise.
   function automatic int pick_socket();
      int live_ids[$];
      for (int i = 0; i < 64; i++) begin
         if (sock_live[i]) live_ids.push_back(i);
      end
      if (live_ids.size() > 0 && $urandom_range(0, 3) != 0) begin
         return live_ids[$urandom_range(0, live_ids.size() - 1)];
      end
      return int'($urandom_range(0, 63));
   endfunction

   function automatic ercq_pkg::req_type make_item(input mix_kind_type mix);
      ercq_pkg::req_type it;
      int                roll;
      int                reg_pct;
      int                unreg_pct;
      int                sig_pct;
      case (mix)
         MIX_FILL:  begin reg_pct = 40; unreg_pct = 10; sig_pct = 30; end
         MIX_CHURN: begin reg_pct = 20; unreg_pct = 20; sig_pct = 35; end
         default:   begin reg_pct = 10; unreg_pct = 30; sig_pct = 20; end
      endcase
      it.user_tag = $urandom;
      it.event_bits = 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      if (roll < reg_pct) begin
         it.action = ercq_pkg::ACT_REGISTER;
         // Mostly random sockets; a live one now and then for the duplicate path.
         if ($urandom_range(0, 4) == 0) begin
            it.socket_id = 6'(pick_socket());
         end else begin
            it.socket_id = 6'($urandom_range(0, 63));
         end
         if ($urandom_range(0, 9) == 0) it.event_bits = 8'h00;
      end else if (roll < reg_pct + unreg_pct) begin
         it.action = ercq_pkg::ACT_UNREGISTER;
         it.socket_id = 6'(pick_socket());
         if ($urandom_range(0, 4) < 2) it.event_bits = 8'hFF;
      end else if (roll < reg_pct + unreg_pct + sig_pct) begin
         it.action = ercq_pkg::ACT_SIGNAL;
         it.socket_id = 6'(pick_socket());
      end else begin
         it.action = ercq_pkg::ACT_POP;
         it.socket_id = 6'($urandom_range(0, 63));
      end
      return it;
   endfunction

   // Offer one item from a falling edge, hold it until taken, record the
   // expectation, then maybe idle for a burst. Returns on a falling edge.
   task automatic offer(input ercq_pkg::req_type it, input bit typed,
                        input ercq_pkg::rsp_type want);
      ercq_pkg::rsp_type res;
      int                gap;
      req_item <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_ready_list(it, res);
      if (typed) res = want;
      pending_results.push_back(res);
      items_sent++;
      @(negedge clock);
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 16);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Drop valid and hold off until every result is back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // ------------------------------------------------------------------
   // Receiver: random stall bursts, one long hold-off on request
   // ------------------------------------------------------------------
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(1, 16) - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result checker: compare each accepted result with the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      ercq_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected, actual 0x%0h", $time, rsp_item);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_item.status));
            check_field("ready_bits", 32'(want.ready_bits), 32'(rsp_item.ready_bits));
            check_field("ready_socket", 32'(want.ready_socket), 32'(rsp_item.ready_socket));
            check_field("ready_tag", want.ready_tag, rsp_item.ready_tag);
            if (want.status < 5) status_seen[want.status]++;
            if (want.status == ercq_pkg::STATUS_OK && want.ready_bits != 8'h00) data_pops++;
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("%0t: run exceeded %0d cycles, %0d results outstanding", $time,
               CYCLE_LIMIT, pending_results.size());
      $display("event_coalescing_ready_queue_top verification failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      ercq_pkg::rsp_type none;
      none = '0;

      // Hold reset, release on a falling edge. The block then
      // sweeps its table while stalling the input; offer() just waits it out.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty pop, zero mask, unknown sockets, duplicate,
      // extremes of tag and socket, coalescing, removal from the middle of
      // the list, partial unregister, dropping a pending event on free.
      add_row(ercq_pkg::ACT_POP, 0, 8'h00, 32'h0, 1, ercq_pkg::STATUS_EMPTY, 0, 0, 32'h0);
      add_row(ercq_pkg::ACT_REGISTER, 0, 8'h00, 32'hFFFFFFFF, 1, ercq_pkg::STATUS_OK,
              0, 0, 32'h0);
      add_row(ercq_pkg::ACT_UNREGISTER, 5, 8'hFF, 32'h0, 1, ercq_pkg::STATUS_NOTREG,
              0, 0, 32'h0);
      add_row(ercq_pkg::ACT_SIGNAL, 5, 8'hFF, 32'h0, 1, ercq_pkg::STATUS_OK, 0, 0, 32'h0);
      add_row(ercq_pkg::ACT_REGISTER, 0, 8'hFF, 32'hFFFFFFFF, 1, ercq_pkg::STATUS_OK,
              0, 0, 32'h0);
      add_row(ercq_pkg::ACT_REGISTER, 0, 8'h01, 32'h0, 1, ercq_pkg::STATUS_DUP,
              0, 0, 32'h0);
      add_row(ercq_pkg::ACT_REGISTER, 63, 8'h01, 32'h0, 1, ercq_pkg::STATUS_OK,
              0, 0, 32'h0);
      add_row(ercq_pkg::ACT_SIGNAL, 0, 8'h00, 32'h0, 0, ercq_pkg::STATUS_OK, 0, 0, 32'h0);
      add_row(ercq_pkg::ACT_SIGNAL, 63, 8'hFE, 32'h0, 0, ercq_pkg::STATUS_OK, 0, 0, 32'h0);
      add_row(ercq_pkg::ACT_SIGNAL, 0, 8'h0F, 32'h0, 0, ercq_pkg::STATUS_OK, 0, 0, 32'h0);
      add_row(ercq_pkg::ACT_SIGNAL, 63, 8'h01, 32'h0, 0, ercq_pkg::STATUS_OK, 0, 0, 32'h0);
      add_row(ercq_pkg::ACT_SIGNAL, 0, 8'hF0, 32'h0, 0, ercq_pkg::STATUS_OK, 0, 0, 32'h0);
      add_row(ercq_pkg::ACT_REGISTER, 10, 8'h80, 32'h12345678, 0, ercq_pkg::STATUS_OK,
              0, 0, 32'h0);
      add_row(ercq_pkg::ACT_SIGNAL, 10, 8'hFF, 32'h0, 0, ercq_pkg::STATUS_OK, 0, 0, 32'h0);
      add_row(ercq_pkg::ACT_UNREGISTER, 63, 8'h01, 32'h0, 0, ercq_pkg::STATUS_OK,
              0, 0, 32'h0);
      add_row(ercq_pkg::ACT_POP, 0, 8'h00, 32'h0, 1, ercq_pkg::STATUS_OK,
              8'hFF, 0, 32'hFFFFFFFF);
      add_row(ercq_pkg::ACT_POP, 0, 8'h00, 32'h0, 1, ercq_pkg::STATUS_OK,
              8'h80, 10, 32'h12345678);
      add_row(ercq_pkg::ACT_POP, 63, 8'hFF, 32'hFFFFFFFF, 1, ercq_pkg::STATUS_EMPTY,
              0, 0, 32'h0);
      add_row(ercq_pkg::ACT_UNREGISTER, 0, 8'h0F, 32'h0, 0, ercq_pkg::STATUS_OK,
              0, 0, 32'h0);
      add_row(ercq_pkg::ACT_SIGNAL, 0, 8'h0F, 32'h0, 0, ercq_pkg::STATUS_OK, 0, 0, 32'h0);
      add_row(ercq_pkg::ACT_SIGNAL, 0, 8'h30, 32'h0, 0, ercq_pkg::STATUS_OK, 0, 0, 32'h0);
      add_row(ercq_pkg::ACT_UNREGISTER, 0, 8'hF0, 32'h0, 0, ercq_pkg::STATUS_OK,
              0, 0, 32'h0);
      add_row(ercq_pkg::ACT_POP, 0, 8'h00, 32'h0, 1, ercq_pkg::STATUS_EMPTY, 0, 0, 32'h0);
      add_row(ercq_pkg::ACT_UNREGISTER, 10, 8'hFF, 32'h0, 0, ercq_pkg::STATUS_OK,
              0, 0, 32'h0);
      add_row(ercq_pkg::ACT_UNREGISTER, 10, 8'hFF, 32'h0, 1, ercq_pkg::STATUS_NOTREG,
              0, 0, 32'h0);

      foreach (dir_rows[i]) offer(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

      // Pause the sender until the block has answered everything.
      wait_drained();

      // Random part: fill, churn and drain mixes, twice over. Early in the
      // second phase the receiver holds off long enough to back the block up;
      // the final stretch runs with no idling at all.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 1 && i == 20) hold_req = 1'b1;
            if (p == PHASE_COUNT - 1 && i == 60) calm = 1'b1;
            offer(make_item(mix_kind_type'(p % 3)), 1'b0, none);
         end
         wait_drained();
      end

      // Let any stray result show up before the verdict.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, pending_results.size());
         fail_count++;
      end

      $display("Ran %0d items, %0d results: %0d ok, %0d full, %0d unregistered, %0d empty",
               items_sent, results_seen, status_seen[ercq_pkg::STATUS_OK],
               status_seen[ercq_pkg::STATUS_FULL], status_seen[ercq_pkg::STATUS_NOTREG],
               status_seen[ercq_pkg::STATUS_EMPTY]);
      $display("%0d dup; popped %0d events with data; %0d signals merged into a pending event",
               status_seen[ercq_pkg::STATUS_DUP], data_pops, merged_signals);
      if (fail_count == 0) begin
         $display("event_coalescing_ready_queue_top verification clean");
      end else begin
         $display("event_coalescing_ready_queue_top verification failed");
      end
      $finish;
   end

endmodule
